// File: hw/rtl/assert_macros.svh
// assertion helpers; clock and reset are taken from the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge outside reset
`define OLKD_CHECK(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("olkd check failed");

// when pre holds, post holds in the next cycle
`define OLKD_IMPLY(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("olkd implication failed");

`else

`define OLKD_CHECK(lbl, expr)
`define OLKD_IMPLY(lbl, pre, post)

`endif

`endif

// File: hw/rtl/olkd_pkg.sv
package olkd_pkg;

   localparam int OPC_W      = 3;
   localparam int ITEM_W     = 32;
   localparam int LEN_W      = 5;
   localparam int STAT_W     = 2;
   localparam int RSP_DATA_W = 40;

   // request opcodes
   typedef enum logic [OPC_W-1:0] {
      OP_APPEND   = 3'd0,
      OP_REM_HEAD = 3'd1,
      OP_REM_TAIL = 3'd2,
      OP_REM_KEY  = 3'd3,
      OP_READ_OUT = 3'd4
   } opcode_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   // one result transfer
   typedef struct packed {
      status_type        status;
      logic [ITEM_W-1:0] item;
      logic [LEN_W-1:0]  length;
      logic              final_res;
   } rsp_entry_type;

endpackage

// File: hw/rtl/ordered_list_with_key_delete.sv
// append, default opcode, any empty-list case: result pushed from the emit state, then back to idle
// remove head or tail: one read of the list memory, then the result is emitted
// remove key: compare entries from the head, then move the entries after the match up to close the gap
// read-out: entries from the memory read port, one entry per cycle while the output buffer is not full
// one request is in work at a time; a two-entry output buffer lets results wait for rsp_tready
// reset clears the list length, head pointer and output buffer; list memory is not cleared
module ordered_list_with_key_delete #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] item, [36:32] length, [39:37] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // final_res
);

   localparam int AW = $clog2(DEPTH);

   logic                          push_valid;
   olkd_pkg::rsp_entry_type       push_entry;
   logic                          ob_full;
   olkd_pkg::rsp_entry_type       pop_entry;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   logic [olkd_pkg::ITEM_W-1:0]   rd_data;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [olkd_pkg::ITEM_W-1:0]   wr_data;

   // request sequencer
   olkd_core #(.DEPTH(DEPTH)) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (olkd_pkg::opcode_type'(req_tuser)),
      .req_operand (req_tdata),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .ob_full     (ob_full),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   // list storage, circular from the head pointer
   olkd_ram #(.DEPTH(DEPTH), .WIDTH(olkd_pkg::ITEM_W)) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // result buffer
   olkd_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (ob_full),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_entry  (pop_entry)
   );

   // result packing
   assign rsp_tdata = {3'b000, pop_entry.length, pop_entry.item};
   assign rsp_tuser = pop_entry.status;
   assign rsp_tlast = pop_entry.final_res;

endmodule

// File: hw/rtl/olkd_ram.sv
module olkd_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds its data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/olkd_outbuf.sv
module olkd_outbuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  olkd_pkg::rsp_entry_type push_entry,
   output logic                    full,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output olkd_pkg::rsp_entry_type pop_entry
);

   olkd_pkg::rsp_entry_type ent_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_entry = ent_ff[rptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wptr_in = do_push ? ~wptr_ff : wptr_ff;
      rptr_in = do_pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/olkd_core.sv
`include "assert_macros.svh"

module olkd_core #(
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  olkd_pkg::opcode_type              req_opcode,
   input  logic [olkd_pkg::ITEM_W-1:0]       req_operand,
   output logic                              push_valid,
   output olkd_pkg::rsp_entry_type           push_entry,
   input  logic                              ob_full,
   output logic                              rd_en,
   output logic [AW-1:0]                     rd_addr,
   input  logic [olkd_pkg::ITEM_W-1:0]       rd_data,
   output logic                              wr_en,
   output logic [AW-1:0]                     wr_addr,
   output logic [olkd_pkg::ITEM_W-1:0]       wr_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = olkd_pkg::LEN_W;
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_EMIT     = 6'b000010,
      ST_RM_DATA  = 6'b000100,
      ST_KEY_CHK  = 6'b001000,
      ST_SHIFT_WR = 6'b010000,
      ST_READ_OUT = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 idx_ff, idx_in;
   olkd_pkg::opcode_type          op_ff, op_in;
   logic [olkd_pkg::ITEM_W-1:0]   key_ff, key_in;
   olkd_pkg::rsp_entry_type       res_ff, res_in;
   logic                          accept;
   logic                          is_last;
   logic [CW-1:0]                 count_dec;

   // circular address: base plus offset, wrapped at the list depth
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[AW-1:0];
   endfunction

   assign accept    = req_valid && req_ready;
   assign count_dec = count_ff - CNT_ONE;
   assign is_last   = ((CW'(idx_ff) + CNT_ONE) == count_ff);
   assign push_entry = (state_ff == ST_READ_OUT) ?
      '{status: olkd_pkg::STAT_OK, item: rd_data, length: LW'(count_ff),
        final_res: is_last} : res_ff;

   // sequencer: one request at a time, one entry per cycle unless ob_full
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      res_in     = res_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      wr_en      = 1'b0;
      wr_addr    = wrap_add(head_ff, idx_ff);
      wr_data    = rd_data;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_opcode;
               key_in   = req_operand;
               idx_in   = '0;
               state_in = ST_EMIT;
               if (req_opcode inside {olkd_pkg::OP_REM_HEAD, olkd_pkg::OP_REM_TAIL,
                                      olkd_pkg::OP_REM_KEY, olkd_pkg::OP_READ_OUT}
                   && count_ff == '0) begin
                  res_in = '{status: olkd_pkg::STAT_EMPTY, item: '0, length: '0,
                             final_res: 1'b1};
               end else begin
                  case (req_opcode)
                     olkd_pkg::OP_APPEND: begin
                        if (count_ff == CNT_MAX) begin
                           res_in = '{status: olkd_pkg::STAT_FULL, item: '0,
                                      length: LW'(count_ff), final_res: 1'b1};
                        end else begin
                           wr_en    = 1'b1;
                           wr_addr  = wrap_add(head_ff, AW'(count_ff));
                           wr_data  = req_operand;
                           count_in = count_ff + CNT_ONE;
                           res_in   = '{status: olkd_pkg::STAT_OK, item: req_operand,
                                        length: LW'(count_ff + CNT_ONE), final_res: 1'b1};
                        end
                     end
                     olkd_pkg::OP_REM_HEAD: begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = ST_RM_DATA;
                     end
                     olkd_pkg::OP_REM_TAIL: begin
                        rd_en    = 1'b1;
                        rd_addr  = wrap_add(head_ff, AW'(count_dec));
                        state_in = ST_RM_DATA;
                     end
                     olkd_pkg::OP_REM_KEY: begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = ST_KEY_CHK;
                     end
                     olkd_pkg::OP_READ_OUT: begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = ST_READ_OUT;
                     end
                     default: begin
                        res_in = '{status: olkd_pkg::STAT_OK, item: '0,
                                   length: LW'(count_ff), final_res: 1'b1};
                     end
                  endcase
               end
            end
         end

         // head or tail entry has been read
         ST_RM_DATA: begin
            count_in = count_dec;
            if (op_ff == olkd_pkg::OP_REM_HEAD) begin
               head_in = wrap_add(head_ff, AW'(1));
            end
            res_in   = '{status: olkd_pkg::STAT_OK, item: rd_data,
                         length: LW'(count_dec), final_res: 1'b1};
            state_in = ST_EMIT;
         end

         // compare the entry at idx with the key, walking from the head
         ST_KEY_CHK: begin
            if (rd_data == key_ff) begin
               res_in.item = rd_data;
               if (is_last) begin
                  count_in = count_dec;
                  res_in   = '{status: olkd_pkg::STAT_OK, item: rd_data,
                               length: LW'(count_dec), final_res: 1'b1};
                  state_in = ST_EMIT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = wrap_add(head_ff, idx_ff + AW'(1));
                  state_in = ST_SHIFT_WR;
               end
            end else if (is_last) begin
               res_in   = '{status: olkd_pkg::STAT_NOT_FOUND, item: '0,
                            length: LW'(count_ff), final_res: 1'b1};
               state_in = ST_EMIT;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_en   = 1'b1;
               rd_addr = wrap_add(head_ff, idx_ff + AW'(1));
            end
         end

         // close the gap: entry idx takes entry idx+1, read of idx+2 overlaps
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = wrap_add(head_ff, idx_ff);
            wr_data = rd_data;
            if ((CW'(idx_ff) + CNT_ONE) == count_dec) begin
               count_in = count_dec;
               res_in   = '{status: olkd_pkg::STAT_OK, item: res_ff.item,
                            length: LW'(count_dec), final_res: 1'b1};
               state_in = ST_EMIT;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_en   = 1'b1;
               rd_addr = wrap_add(head_ff, idx_ff + AW'(2));
            end
         end

         // one entry per cycle; read data holds while the output is full
         ST_READ_OUT: begin
            if (!ob_full) begin
               push_valid = 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in  = idx_ff + AW'(1);
                  rd_en   = 1'b1;
                  rd_addr = wrap_add(head_ff, idx_ff + AW'(1));
               end
            end
         end

         ST_EMIT: begin
            if (!ob_full) begin
               push_valid = 1'b1;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // request payload and pending result
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      op_ff  <= op_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

   `OLKD_CHECK(a_count_bound, count_ff <= CNT_MAX)
   `OLKD_CHECK(a_head_bound, {1'b0, head_ff} < DEPTH_W)
   `OLKD_IMPLY(a_full_append_keeps, accept && req_opcode == olkd_pkg::OP_APPEND && count_ff == CNT_MAX, $stable(count_ff) && $stable(head_ff))
   `OLKD_IMPLY(a_last_ends_request, push_valid && push_entry.final_res, state_ff == ST_IDLE)
   `OLKD_IMPLY(a_busy_no_accept, state_ff != ST_IDLE, !$past(accept) || state_ff != ST_IDLE)

endmodule
